[hdl/dssp_pkg.sv]
// dssp_pkg: shared types, constants and codes for the dense shortest path block
// used by dssp_cell and dense_single_source_shortest_path
`timescale 1ns / 1ps

package dssp_pkg;

    localparam int NODES_DEF = 8;
    localparam int NODES_MAX = 64;
    localparam int IDX_W     = $clog2(NODES_MAX);
    localparam int CNT_W     = $clog2(NODES_MAX + 1);
    localparam int FLAT_W    = 2 * IDX_W;
    localparam int COST_W    = 16;

    localparam logic [COST_W-1:0] RESET_COST       = 16'd100;
    localparam logic [3:0]        NODE_COUNT_RESET = 4'd8;
    localparam logic [COST_W-1:0] NO_EDGE_RESET    = 16'd100;

    typedef enum logic {
        CFG_NODE_COUNT   = 1'b0,
        CFG_NO_EDGE_COST = 1'b1
    } cfg_index_t;

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_RUN  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  from_node;
        logic [2:0]  to_node;
        logic [15:0] edge_weight;
        logic [2:0]  source_node;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  node_index;
        logic [15:0] distance;
        logic        last;
    } res_item_t;

    // token walking down the cell row, one cell per cycle
    typedef struct packed {
        logic              valid;
        logic              relax;
        logic [IDX_W-1:0]  u;
        logic [COST_W-1:0] du;
        logic [COST_W-1:0] best;
        logic [IDX_W-1:0]  sel;
    } token_t;

    // run-wide settings seen by every cell
    typedef struct packed {
        logic [CNT_W-1:0]  n;
        logic [IDX_W-1:0]  src;
        logic [COST_W-1:0] ceiling;
    } run_ctl_t;

endpackage

[hdl/dssp_ram.sv]
// dssp_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module dssp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/dssp_cell.sv]
// dssp_cell: one node of the row; holds its distance and done flag,
// relaxes against the passing token and hands the token on. depends on dssp_pkg
`timescale 1ns / 1ps

module dssp_cell import dssp_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  token_t            tok_in,
    input  logic [COST_W-1:0] cost,
    input  run_ctl_t          run,
    input  logic              shift,
    input  logic [COST_W-1:0] shift_in,
    output token_t            tok_out,
    output logic [COST_W-1:0] node_dist
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    token_t            tok_reg, tok_next;
    logic [COST_W-1:0] dist_reg, dist_next;
    logic              fin_reg, fin_next;
    logic              active, is_src, cand;
    logic [COST_W-1:0] cost_sat, sum_sat;
    logic [COST_W:0]   sum;

    always_comb
    begin
        active   = CNT_W'(CELL_IDX) < run.n;
        is_src   = MY_IDX == run.src;
        cost_sat = (cost < run.ceiling) ? cost : run.ceiling;
        sum      = {1'b0, tok_in.du} + {1'b0, cost};
        sum_sat  = (sum > {1'b0, run.ceiling}) ? run.ceiling : sum[COST_W-1:0];

        dist_next = dist_reg;
        fin_next  = fin_reg;
        if (shift)
        begin
            dist_next = shift_in;
        end
        else if (tok_in.valid && active)
        begin
            if (!tok_in.relax)
            begin
                // load the source row
                fin_next  = is_src;
                dist_next = is_src ? '0 : cost_sat;
            end
            else if (MY_IDX == tok_in.u)
            begin
                fin_next = 1'b1;
            end
            else if (!fin_reg && !is_src && (sum_sat < dist_reg))
            begin
                dist_next = sum_sat;
            end
        end

        // running minimum for the next pick, strict compare keeps lowest index
        cand     = tok_in.valid && active && !fin_next && (dist_next < tok_in.best);
        tok_next = tok_in;
        if (cand)
        begin
            tok_next.best = dist_next;
            tok_next.sel  = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        fin_reg  <= fin_next;
    end

    assign tok_out   = tok_reg;
    assign node_dist = dist_reg;

endmodule

[hdl/dense_single_source_shortest_path.sv]
// dense_single_source_shortest_path: top level, controller, cost matrix and cell row
// depends on dssp_pkg, dssp_ram, dssp_cell
//
// usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) takes one item at a time. an edge
//   item writes one cost of the NODES x NODES matrix and gives no result. a run
//   item computes distances from source_node.
//   res channel (res_valid / res_stall / res) delivers one item per node in use,
//   node 0 first, last set on the final one.
//   wr_en / wr_index / wr_data write node_count and no_edge_cost while idle.
// run sequence:
//   a run makes one load pass plus n-2 relax passes, one matrix read per cycle
//   while a token walks the cell row; the results then follow at one per cycle
//   unless res_stall holds them, and the next item is taken only once the last
//   result has been loaded.
// reset:
//   the matrix is cleared to 0 on the diagonal and 100 elsewhere by a pass over
//   all NODES*NODES entries, one entry per cycle; cmd_stall stays high meanwhile.
// stalls:
//   results sit in an output register; with res_stall high the run holds before
//   the next result, and cmd_stall stays high until the last result is loaded.
`timescale 1ns / 1ps

module dense_single_source_shortest_path import dssp_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_item_t   cmd,
    output logic        res_valid,
    input  logic        res_stall,
    output res_item_t   res,
    input  logic        wr_en,
    input  logic [0:0]  wr_index,
    input  logic [15:0] wr_data
);

    localparam int DEPTH = NODES * NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NODES - 1);
    localparam logic [CNT_W-1:0]  NODES_CNT = CNT_W'(NODES);
    localparam logic [FLAT_W-1:0] ROW_STEP  = FLAT_W'(NODES);

    state_t            state_reg, state_next;
    logic [3:0]        node_count_reg;
    logic [COST_W-1:0] ceiling_reg;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    run_ctl_t          run_reg, run_next;
    logic [IDX_W-1:0]  pass_u_reg, pass_u_next;
    logic [COST_W-1:0] du_reg, du_next;
    logic              relax_reg, relax_next;
    logic [CNT_W-1:0]  passes_reg, passes_next;
    logic [CNT_W-1:0]  emit_cnt_reg, emit_cnt_next;
    token_t            tok0_reg, tok0_next;
    res_item_t         res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    logic              cmd_take, edge_ok, emit_load, emit_last;
    logic [CNT_W-1:0]  n_ext, n_eff, src_ext;
    logic [IDX_W-1:0]  src_eff, wr_row, wr_col;
    logic [FLAT_W-1:0] wr_flat, rd_flat;
    logic              ram_we;
    logic [COST_W-1:0] ram_wdata, ram_rdata;

    token_t            tok_chain  [NODES+1];
    logic [COST_W-1:0] dist_chain [NODES+1];

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
            ceiling_reg    <= NO_EDGE_RESET;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                CFG_NODE_COUNT:   node_count_reg <= wr_data[3:0];
                CFG_NO_EDGE_COST: ceiling_reg    <= wr_data;
                default:          node_count_reg <= node_count_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------- run setup
    always_comb
    begin
        cmd_take = cmd_valid && !cmd_stall;
        n_ext    = CNT_W'(node_count_reg);
        if (n_ext > NODES_CNT)
        begin
            n_eff = NODES_CNT;
        end
        else if (n_ext == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else
        begin
            n_eff = n_ext;
        end
        src_ext = CNT_W'(cmd.source_node);
        src_eff = (src_ext >= n_eff) ? IDX_W'(n_eff - CNT_W'(1)) : IDX_W'(src_ext);
        edge_ok = (CNT_W'(cmd.from_node) < NODES_CNT) && (CNT_W'(cmd.to_node) < NODES_CNT);
    end

    // ---------------------------------------------------------------- matrix
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            wr_row    = row_reg;
            wr_col    = col_reg;
            ram_we    = 1'b1;
            ram_wdata = (row_reg == col_reg) ? '0 : RESET_COST;
        end
        else
        begin
            wr_row    = IDX_W'(cmd.from_node);
            wr_col    = IDX_W'(cmd.to_node);
            ram_we    = cmd_take && (cmd.op == OP_EDGE) && edge_ok;
            ram_wdata = cmd.edge_weight;
        end
        wr_flat = FLAT_W'(wr_row) * ROW_STEP + FLAT_W'(wr_col);
        rd_flat = FLAT_W'(pass_u_reg) * ROW_STEP + FLAT_W'(col_reg);
    end

    dssp_ram #(
        .WIDTH (COST_W),
        .DEPTH (DEPTH)
    ) u_costs (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (AW'(wr_flat)),
        .wr_data (ram_wdata),
        .rd_addr (AW'(rd_flat)),
        .rd_data (ram_rdata)
    );

    // ---------------------------------------------------------------- cell row
    assign tok_chain[0]      = tok0_reg;
    assign dist_chain[NODES] = '0;

    for (genvar k = 0; k < NODES; k++)
    begin : g_cell
        dssp_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tok_in    (tok_chain[k]),
            .cost      (ram_rdata),
            .run       (run_reg),
            .shift     (emit_load),
            .shift_in  (dist_chain[k+1]),
            .tok_out   (tok_chain[k+1]),
            .node_dist (dist_chain[k])
        );
    end

    // ---------------------------------------------------------------- control
    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        run_next       = run_reg;
        pass_u_next    = pass_u_reg;
        du_next        = du_reg;
        relax_next     = relax_reg;
        passes_next    = passes_reg;
        emit_cnt_next  = emit_cnt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        emit_load      = 1'b0;
        emit_last      = emit_cnt_reg == (run_reg.n - CNT_W'(1));

        // token enters cell 0 together with the first column read
        tok0_next.valid = (state_reg == ST_ISSUE) && (col_reg == '0);
        tok0_next.relax = relax_reg;
        tok0_next.u     = pass_u_reg;
        tok0_next.du    = du_reg;
        tok0_next.best  = run_reg.ceiling;
        tok0_next.sel   = run_reg.src;

        unique case (state_reg)
            ST_CLEAR:
            begin
                col_next = col_reg + IDX_W'(1);
                if (col_reg == LAST_IDX)
                begin
                    col_next = '0;
                    row_next = row_reg + IDX_W'(1);
                    if (row_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (cmd_take && (cmd.op == OP_RUN))
                begin
                    run_next.n       = n_eff;
                    run_next.src     = src_eff;
                    run_next.ceiling = ceiling_reg;
                    pass_u_next      = src_eff;
                    du_next          = '0;
                    relax_next       = 1'b0;
                    passes_next      = (n_eff >= CNT_W'(2)) ? (n_eff - CNT_W'(2)) : '0;
                    col_next         = '0;
                    state_next       = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                col_next = col_reg + IDX_W'(1);
                if (col_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (tok_chain[NODES].valid)
                begin
                    if (passes_reg != '0)
                    begin
                        pass_u_next = tok_chain[NODES].sel;
                        du_next     = tok_chain[NODES].best;
                        relax_next  = 1'b1;
                        passes_next = passes_reg - CNT_W'(1);
                        col_next    = '0;
                        state_next  = ST_ISSUE;
                    end
                    else
                    begin
                        emit_cnt_next = '0;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    // cell 0 holds the next distance, the row shifts toward it
                    emit_load           = 1'b1;
                    res_next.node_index = emit_cnt_reg[2:0];
                    res_next.distance   = dist_chain[0];
                    res_next.last       = emit_last;
                    res_valid_next      = 1'b1;
                    emit_cnt_next       = emit_cnt_reg + CNT_W'(1);
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            col_reg       <= '0;
            passes_reg    <= '0;
            emit_cnt_reg  <= '0;
            relax_reg     <= 1'b0;
            tok0_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            passes_reg    <= passes_next;
            emit_cnt_reg  <= emit_cnt_next;
            relax_reg     <= relax_next;
            tok0_reg      <= tok0_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg    <= run_next;
        pass_u_reg <= pass_u_next;
        du_reg     <= du_next;
        res_reg    <= res_next;
    end

    assign cmd_stall = state_reg != ST_IDLE;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
